// ===== sv/hss_pkg.sv =====
// Shared types and constants for the Horspool substring search block.
`default_nettype none

package hss_pkg;

   // Default sizing of the top level
   localparam int TEXT_DEPTH_DEFAULT  = 1024;
   localparam int PATTERN_MAX_DEFAULT = 16;

   // Pattern storage is fixed by the two 64-bit pattern registers
   localparam int PAT_BYTES = 16;
   localparam int PAT_IDX_W = 4;
   localparam int PAT_LEN_W = 5;

   // Configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 64;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PATTERN_LOW    = 2'd0,
      CSR_PATTERN_HIGH   = 2'd1,
      CSR_PATTERN_LENGTH = 2'd2
   } csr_index_type;

   // Search engine sequencer
   typedef enum logic [1:0] {
      SEARCH_IDLE,
      SEARCH_ISSUE,
      SEARCH_COMPARE,
      SEARCH_FINISH
   } search_state_type;

   // Back end hands a text bank back to the front end
   typedef struct packed {
      logic valid;
      logic bank;
   } bank_release_type;

   // Front end bank bookkeeping
   typedef struct packed {
      logic [1:0] bank_busy;
      logic       wr_bank;
   } front_status_type;

endpackage

`default_nettype wire

// ===== sv/hss_front.sv =====
// Front end: takes text bytes, fills the text banks and queues one search job per text.
`default_nettype none

module hss_front #(
   parameter int TEXT_DEPTH = hss_pkg::TEXT_DEPTH_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [7:0]                    req_text_byte,
   input  wire logic                          req_last_byte,
   input  wire logic                          q_full,
   output logic                               q_push,
   output logic [$clog2(TEXT_DEPTH+1)+1:0]    q_push_data,
   output logic                               wr_en,
   output logic [$clog2(TEXT_DEPTH):0]        wr_addr,
   output logic [7:0]                         wr_data,
   input  wire hss_pkg::bank_release_type     bank_release,
   output hss_pkg::front_status_type          status
);

   localparam int CNT_W  = $clog2(TEXT_DEPTH + 1);
   localparam int ADDR_W = $clog2(TEXT_DEPTH);

   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic [CNT_W-1:0] count_after;
   logic             ovf_ff;
   logic             ovf_in;
   logic             ovf_after;
   logic             wr_bank_ff;
   logic             wr_bank_in;
   logic [1:0]       bank_busy_ff;
   logic [1:0]       bank_busy_in;
   logic             accept;
   logic             room;

   // Take bytes only into a bank the back end has handed back
   assign req_ready = !bank_busy_ff[wr_bank_ff] && !q_full;
   assign accept    = req_valid && req_ready;
   assign room      = count_ff < CNT_W'(TEXT_DEPTH);

   // Store the byte while there is room, drop and flag it otherwise
   assign wr_en       = accept && room;
   assign wr_addr     = {wr_bank_ff, count_ff[ADDR_W-1:0]};
   assign wr_data     = req_text_byte;
   assign count_after = count_ff + CNT_W'(room);
   assign ovf_after   = ovf_ff || !room;

   // Hand the finished text to the back end
   assign q_push      = accept && req_last_byte;
   assign q_push_data = {wr_bank_ff, count_after, ovf_after};

   assign status.bank_busy = bank_busy_ff;
   assign status.wr_bank   = wr_bank_ff;

   // Advance the fill state
   always_comb begin
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      wr_bank_in   = wr_bank_ff;
      bank_busy_in = bank_busy_ff;
      if (accept) begin
         count_in = req_last_byte ? '0 : count_after;
         ovf_in   = req_last_byte ? 1'b0 : ovf_after;
      end
      if (bank_release.valid) begin
         bank_busy_in[bank_release.bank] = 1'b0;
      end
      if (q_push) begin
         bank_busy_in[wr_bank_ff] = 1'b1;
         wr_bank_in               = !wr_bank_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         wr_bank_ff   <= 1'b0;
         bank_busy_ff <= '0;
      end else begin
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         wr_bank_ff   <= wr_bank_in;
         bank_busy_ff <= bank_busy_in;
      end
   end

endmodule

`default_nettype wire

// ===== sv/hss_job_queue.sv =====
// Two-entry job queue between the front end and the search engine.
`default_nettype none

module hss_job_queue #(
   parameter int TEXT_DEPTH = hss_pkg::TEXT_DEPTH_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              push,
   input  wire logic [$clog2(TEXT_DEPTH+1)+1:0]   push_data,
   input  wire logic                              pop,
   output logic [$clog2(TEXT_DEPTH+1)+1:0]        pop_data,
   output logic                                   full,
   output logic                                   empty,
   output logic [1:0]                             count
);

   localparam int JOB_W = $clog2(TEXT_DEPTH + 1) + 2;

   logic [JOB_W-1:0] entry_ff [2];
   logic             wr_ptr_ff;
   logic             rd_ptr_ff;
   logic [1:0]       count_ff;
   logic             do_push;
   logic             do_pop;

   assign full     = count_ff == 2'd2;
   assign empty    = count_ff == 2'd0;
   assign count    = count_ff;
   assign pop_data = entry_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   // Hold job payloads
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   // Advance pointers and occupancy
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (do_pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         count_ff <= count_ff + 2'(do_push) - 2'(do_pop);
      end
   end

endmodule

`default_nettype wire

// ===== sv/hss_back.sv =====
// Back end: text memory, Horspool search sequencer and result register.
`default_nettype none

module hss_back #(
   parameter int TEXT_DEPTH  = hss_pkg::TEXT_DEPTH_DEFAULT,
   parameter int PATTERN_MAX = hss_pkg::PATTERN_MAX_DEFAULT
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic [hss_pkg::PAT_BYTES*8-1:0]      pattern,
   input  wire logic [hss_pkg::PAT_LEN_W-1:0]        pattern_length,
   input  wire logic                                 wr_en,
   input  wire logic [$clog2(TEXT_DEPTH):0]          wr_addr,
   input  wire logic [7:0]                           wr_data,
   input  wire logic                                 q_empty,
   input  wire logic [$clog2(TEXT_DEPTH+1)+1:0]      q_data,
   output logic                                      q_pop,
   output hss_pkg::bank_release_type                 bank_release,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output logic                                      rsp_found,
   output logic                                      rsp_text_truncated
);

   localparam int CNT_W     = $clog2(TEXT_DEPTH + 1);
   localparam int ADDR_W    = $clog2(TEXT_DEPTH);
   localparam int JOB_W     = CNT_W + 2;
   localparam int POS_W     = CNT_W + 1;
   localparam int LEN_W     = $clog2(PATTERN_MAX + 1);
   localparam int K_W       = $clog2(PATTERN_MAX);
   localparam int MEM_DEPTH = 2 ** (ADDR_W + 1);

   // Last-occurrence shift of byte c over the first len-1 pattern bytes
   function automatic logic [LEN_W-1:0] horspool_shift(
      input logic [hss_pkg::PAT_BYTES*8-1:0] pat,
      input logic [LEN_W-1:0]                len,
      input logic [7:0]                      c
   );
      logic [LEN_W-1:0] sh;
      sh = len;
      for (int i = 0; i < PATTERN_MAX - 1; i++) begin
         if (((LEN_W'(i) + 1'b1) < len) && (pat[i*8 +: 8] == c)) begin
            sh = len - LEN_W'(i) - 1'b1;
         end
      end
      return sh;
   endfunction

   logic [7:0]                    mem [MEM_DEPTH];
   logic [7:0]                    rd_data_ff;
   logic                          rd_en;
   logic [ADDR_W:0]               rd_addr;
   logic [POS_W-1:0]              rd_pos;

   hss_pkg::search_state_type     state_ff;
   hss_pkg::search_state_type     state_in;

   logic                          bank_ff;
   logic [CNT_W-1:0]              count_ff;
   logic                          ovf_ff;
   logic [LEN_W-1:0]              len_ff;
   logic [POS_W-1:0]              pos_ff;
   logic [K_W-1:0]                k_ff;
   logic [7:0]                    last_ff;
   logic                          found_ff;
   logic                          rsp_valid_ff;
   logic                          rsp_found_ff;
   logic                          rsp_trunc_ff;

   logic [7:0]                    pat_bytes [hss_pkg::PAT_BYTES];
   logic [7:0]                    pat_k;
   logic [LEN_W-1:0]              eff_len;
   logic                          q_bank;
   logic [CNT_W-1:0]              q_count;
   logic                          q_ovf;
   logic                          start_empty;
   logic                          first_cmp;
   logic                          byte_match;
   logic                          k_zero;
   logic [7:0]                    win_last;
   logic [LEN_W-1:0]              shift_amt;
   logic [POS_W-1:0]              pos_shifted;
   logic                          past_end;
   logic                          slot_free;
   logic                          finish_load;

   // Text memory: one write port from the front end, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // Split the pattern into bytes
   always_comb begin
      for (int b = 0; b < hss_pkg::PAT_BYTES; b++) begin
         pat_bytes[b] = pattern[b*8 +: 8];
      end
   end

   // Clamp the configured length
   assign eff_len = (pattern_length > hss_pkg::PAT_LEN_W'(PATTERN_MAX))
                  ? LEN_W'(PATTERN_MAX) : pattern_length[LEN_W-1:0];

   assign q_bank      = q_data[JOB_W-1];
   assign q_count     = q_data[JOB_W-2:1];
   assign q_ovf       = q_data[0];
   assign start_empty = (eff_len == '0) || (POS_W'(eff_len) > POS_W'(q_count));

   // Window compare terms
   assign pat_k       = pat_bytes[hss_pkg::PAT_IDX_W'(k_ff)];
   assign first_cmp   = k_ff == K_W'(len_ff - 1'b1);
   assign byte_match  = rd_data_ff == pat_k;
   assign k_zero      = k_ff == '0;
   assign win_last    = first_cmp ? rd_data_ff : last_ff;
   assign shift_amt   = horspool_shift(pattern, len_ff, win_last);
   assign pos_shifted = pos_ff + POS_W'(shift_amt);
   assign past_end    = (pos_shifted + POS_W'(len_ff)) > POS_W'(count_ff);
   assign slot_free   = !rsp_valid_ff || rsp_ready;

   assign rd_pos  = pos_ff + POS_W'(k_ff);
   assign rd_addr = {bank_ff, rd_pos[ADDR_W-1:0]};

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         hss_pkg::SEARCH_IDLE: begin
            if (!q_empty) begin
               state_in = start_empty ? hss_pkg::SEARCH_FINISH : hss_pkg::SEARCH_ISSUE;
            end
         end
         hss_pkg::SEARCH_ISSUE: begin
            state_in = hss_pkg::SEARCH_COMPARE;
         end
         hss_pkg::SEARCH_COMPARE: begin
            if (byte_match && k_zero) begin
               state_in = hss_pkg::SEARCH_FINISH;
            end else if (byte_match) begin
               state_in = hss_pkg::SEARCH_ISSUE;
            end else if (past_end) begin
               state_in = hss_pkg::SEARCH_FINISH;
            end else begin
               state_in = hss_pkg::SEARCH_ISSUE;
            end
         end
         hss_pkg::SEARCH_FINISH: begin
            if (slot_free) begin
               state_in = hss_pkg::SEARCH_IDLE;
            end
         end
         default: begin
            state_in = hss_pkg::SEARCH_IDLE;
         end
      endcase
   end

   // Sequencer outputs
   always_comb begin
      q_pop       = 1'b0;
      rd_en       = 1'b0;
      finish_load = 1'b0;
      case (state_ff)
         hss_pkg::SEARCH_IDLE:    q_pop       = !q_empty;
         hss_pkg::SEARCH_ISSUE:   rd_en       = 1'b1;
         hss_pkg::SEARCH_COMPARE: rd_en       = 1'b0;
         hss_pkg::SEARCH_FINISH:  finish_load = slot_free;
         default:                 q_pop       = 1'b0;
      endcase
   end

   assign bank_release.valid = finish_load;
   assign bank_release.bank  = bank_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= hss_pkg::SEARCH_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Load a job, then step the window position and compare index
   always_ff @(posedge clock) begin
      if (q_pop) begin
         bank_ff  <= q_bank;
         count_ff <= q_count;
         ovf_ff   <= q_ovf;
         len_ff   <= eff_len;
         pos_ff   <= '0;
         k_ff     <= K_W'(eff_len - 1'b1);
         found_ff <= 1'b0;
      end else if (state_ff == hss_pkg::SEARCH_COMPARE) begin
         if (first_cmp) begin
            last_ff <= rd_data_ff;
         end
         if (byte_match) begin
            if (k_zero) begin
               found_ff <= 1'b1;
            end else begin
               k_ff <= k_ff - 1'b1;
            end
         end else begin
            pos_ff <= pos_shifted;
            k_ff   <= K_W'(len_ff - 1'b1);
         end
      end
   end

   // Result register: hold until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (finish_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (finish_load) begin
         rsp_found_ff <= found_ff;
         rsp_trunc_ff <= ovf_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_found          = rsp_found_ff;
   assign rsp_text_truncated = rsp_trunc_ff;

endmodule

`default_nettype wire

// ===== sv/horspool_substring_search_top.sv =====
// Horspool substring search: top level with pattern registers and checks.
// Text bytes are taken one per cycle, while req_ready is high, into one of two text banks.
// With an idle search engine the job is popped from the queue after the marked last byte, each
// byte compare passes through an issue and a compare state, and the finish state loads the result.
// The next text fills the other bank meanwhile; input stalls while both banks are busy.
// Reset is synchronous and active high; text memory is not cleared and needs no clearing pass.
`default_nettype none

module horspool_substring_search_top #(
   parameter int TEXT_DEPTH  = hss_pkg::TEXT_DEPTH_DEFAULT,
   parameter int PATTERN_MAX = hss_pkg::PATTERN_MAX_DEFAULT
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire logic [7:0]                       req_text_byte,
   input  wire logic                             req_last_byte,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output logic                                  rsp_found,
   output logic                                  rsp_text_truncated,
   input  wire logic                             csr_wr_en,
   input  wire logic [hss_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [hss_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam int JOB_W  = $clog2(TEXT_DEPTH + 1) + 2;
   localparam int ADDR_W = $clog2(TEXT_DEPTH);

   logic [hss_pkg::CSR_DATA_W-1:0]  pattern_low_ff;
   logic [hss_pkg::CSR_DATA_W-1:0]  pattern_high_ff;
   logic [hss_pkg::PAT_LEN_W-1:0]   pattern_length_ff;

   logic                            q_push;
   logic [JOB_W-1:0]                q_push_data;
   logic                            q_pop;
   logic [JOB_W-1:0]                q_pop_data;
   logic                            q_full;
   logic                            q_empty;
   logic [1:0]                      q_count;
   logic                            wr_en;
   logic [ADDR_W:0]                 wr_addr;
   logic [7:0]                      wr_data;
   hss_pkg::bank_release_type       bank_release;
   hss_pkg::front_status_type       front_status;

   // Pattern registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_low_ff    <= '0;
         pattern_high_ff   <= '0;
         pattern_length_ff <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            hss_pkg::CSR_PATTERN_LOW:    pattern_low_ff    <= csr_wdata;
            hss_pkg::CSR_PATTERN_HIGH:   pattern_high_ff   <= csr_wdata;
            hss_pkg::CSR_PATTERN_LENGTH:
               pattern_length_ff <= csr_wdata[hss_pkg::PAT_LEN_W-1:0];
            default:                     pattern_low_ff    <= pattern_low_ff;
         endcase
      end
   end

   hss_front #(
      .TEXT_DEPTH (TEXT_DEPTH)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_text_byte (req_text_byte),
      .req_last_byte (req_last_byte),
      .q_full        (q_full),
      .q_push        (q_push),
      .q_push_data   (q_push_data),
      .wr_en         (wr_en),
      .wr_addr       (wr_addr),
      .wr_data       (wr_data),
      .bank_release  (bank_release),
      .status        (front_status)
   );

   hss_job_queue #(
      .TEXT_DEPTH (TEXT_DEPTH)
   ) u_job_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .pop       (q_pop),
      .pop_data  (q_pop_data),
      .full      (q_full),
      .empty     (q_empty),
      .count     (q_count)
   );

   hss_back #(
      .TEXT_DEPTH  (TEXT_DEPTH),
      .PATTERN_MAX (PATTERN_MAX)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .pattern            ({pattern_high_ff, pattern_low_ff}),
      .pattern_length     (pattern_length_ff),
      .wr_en              (wr_en),
      .wr_addr            (wr_addr),
      .wr_data            (wr_data),
      .q_empty            (q_empty),
      .q_data             (q_pop_data),
      .q_pop              (q_pop),
      .bank_release       (bank_release),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_found          (rsp_found),
      .rsp_text_truncated (rsp_text_truncated)
   );

   // Every queued job owns a busy bank
   a_queue_backed: assert property (@(posedge clock) disable iff (reset)
      32'(q_count) <= $countones(front_status.bank_busy))
      else $error("queued jobs exceed busy text banks");

   // Bytes never land in a bank still waiting for search
   a_accept_free_bank: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |-> !front_status.bank_busy[front_status.wr_bank])
      else $error("byte accepted into a busy text bank");

   // Only a busy bank is handed back
   a_release_busy: assert property (@(posedge clock) disable iff (reset)
      bank_release.valid |-> front_status.bank_busy[bank_release.bank])
      else $error("release of a text bank that is not busy");

   // A new result always comes with the release of its bank
   a_rsp_with_release: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(bank_release.valid))
      else $error("result shown without a finished search");

endmodule

`default_nettype wire
